/* hw/rtl/peer_horizon_grant_barrier_defines.svh */
// -----------------------------------------------------------------------------
// peer_horizon_grant_barrier_defines
// Assertion macros shared by the barrier RTL.
// -----------------------------------------------------------------------------
`ifndef PEER_HORIZON_GRANT_BARRIER_DEFINES_SVH
`define PEER_HORIZON_GRANT_BARRIER_DEFINES_SVH

// same-cycle implication
`define PHGB_ASSERT_IMP(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define PHGB_ASSERT_NXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error(msg);

`endif

/* hw/rtl/phgb_pkg.sv */
// -----------------------------------------------------------------------------
// phgb_pkg
// Types and constants of the peer horizon grant barrier.
// -----------------------------------------------------------------------------
package phgb_pkg;

  localparam int unsigned NumPortsDef = 4;
  localparam int unsigned TickBitsDef = 64;
  localparam int unsigned RatePorts   = 4;
  localparam int unsigned ProdBits    = 96;
  localparam int unsigned DivSteps    = 96;
  localparam int unsigned AddrBits    = 5;

  typedef enum logic [2:0] {
    REG_RATE0    = 3'd0,
    REG_RATE1    = 3'd1,
    REG_RATE2    = 3'd2,
    REG_RATE3    = 3'd3,
    REG_GROUPS   = 3'd4,
    REG_ATTACHED = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    VERD_GRANT = 2'd0,
    VERD_UNB   = 2'd1,
    VERD_WAIT  = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SELF,
    ST_SCAN,
    ST_PEER,
    ST_MUL_HI,
    ST_DIV,
    ST_BOUND,
    ST_FINISH
  } state_e;

endpackage

/* hw/rtl/phgb_req_if.sv */
// -----------------------------------------------------------------------------
// phgb_req_if
// Request channel: port, local, safe and wanted ticks.
// -----------------------------------------------------------------------------
interface phgb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  port_sel;
  logic [63:0] local_now;
  logic [63:0] safe_horizon;
  logic [63:0] wanted_tick;

  modport source (output valid, port_sel, local_now, safe_horizon, wanted_tick,
                  input ready);
  modport sink (input valid, port_sel, local_now, safe_horizon, wanted_tick,
                output ready);
endinterface

/* hw/rtl/phgb_rsp_if.sv */
// -----------------------------------------------------------------------------
// phgb_rsp_if
// Result channel: verdict and granted tick.
// -----------------------------------------------------------------------------
interface phgb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [63:0] grant_tick;

  modport source (output valid, verdict, grant_tick, input ready);
  modport sink (input valid, verdict, grant_tick, output ready);
endinterface

/* hw/rtl/peer_horizon_grant_barrier.sv */
// -----------------------------------------------------------------------------
// peer_horizon_grant_barrier
// Flow: a port that is not attached goes straight to the result; else its anchor
// is updated and the group is scanned. An anchored attached peer whose span needs
// rate conversion passes two 32x32 multiply steps and a 96-step restoring divider.
// Throughput: one word in flight; the next word is taken once the result is
// in the output register. Port state sits in two RAMs with registered read data.
// Reset: valid flags clear at once, so stored spans and grants read as zero; rates 1.
// -----------------------------------------------------------------------------
`include "peer_horizon_grant_barrier_defines.svh"

module peer_horizon_grant_barrier #(
  parameter int unsigned NUM_PORTS = phgb_pkg::NumPortsDef,
  parameter int unsigned TICK_BITS = phgb_pkg::TickBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  phgb_req_if.sink                      req_i,
  phgb_rsp_if.source                    rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [phgb_pkg::AddrBits-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import phgb_pkg::*;

  localparam int unsigned PortW     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned QW        = $clog2(NUM_PORTS + 1);
  localparam int unsigned PortLimit = (NUM_PORTS < RatePorts) ? NUM_PORTS : RatePorts;
  localparam int unsigned CntW      = $clog2(DivSteps);
  localparam logic [TICK_BITS-1:0] TickMask = '1;

  // configuration
  logic [31:0] rate_q [RatePorts];
  logic [7:0]  groups_q;
  logic [3:0]  att_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_RATE0:    prdata = rate_q[0];
      REG_RATE1:    prdata = rate_q[1];
      REG_RATE2:    prdata = rate_q[2];
      REG_RATE3:    prdata = rate_q[3];
      REG_GROUPS:   prdata = {24'd0, groups_q};
      REG_ATTACHED: prdata = {28'd0, att_q};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RatePorts; i++) rate_q[i] <= 32'd1;
      groups_q <= '0;
      att_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RATE0, REG_RATE1, REG_RATE2, REG_RATE3: begin
          if (32'(paddr[4:2]) < PortLimit) rate_q[paddr[3:2]] <= pwdata;
        end
        REG_GROUPS:   groups_q <= pwdata[7:0];
        REG_ATTACHED: att_q    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  function automatic logic att_of(int unsigned p, logic [3:0] att);
    logic [1:0] s;
    s = 2'(p);
    return (p < RatePorts) ? att[s] : 1'b0;
  endfunction

  function automatic logic [1:0] grp_of(int unsigned p, logic [7:0] grp);
    logic [1:0] s;
    s = 2'(p);
    return (p < RatePorts) ? grp[{s, 1'b0} +: 2] : 2'd0;
  endfunction

  // state
  state_e                 state_q, state_d;
  logic [PortW-1:0]       p_q, p_d;
  logic                   selok_q, selok_d;
  logic [TICK_BITS-1:0]   loc_q, loc_d, safe_q, safe_d, want_q, want_d;
  logic [TICK_BITS-1:0]   origin_q, origin_d, lg_q, lg_d;
  logic [TICK_BITS-1:0]   ceil_q, ceil_d, span_q, span_d, conv_q, conv_d;
  logic                   any_q, any_d;
  logic [QW-1:0]          q_q, q_d;
  logic [63:0]            plo_q, plo_d;
  logic [ProdBits-1:0]    dvd_q, dvd_d;
  logic [31:0]            rem_q, rem_d, from_q, from_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_vld_q, out_vld_d;
  verdict_e               out_verd_q, out_verd_d;
  logic [63:0]            out_tick_q, out_tick_d;
  logic [NUM_PORTS-1:0]   anch_q, anch_d, lgv_q, lgv_d;

  // memories
  logic                   a_we, b_we;
  logic [PortW-1:0]       a_waddr, a_raddr;
  logic [2*TICK_BITS-1:0] a_wdata, a_rdata;
  logic [TICK_BITS-1:0]   b_wdata, b_rdata;

  phgb_ram #(.Width(2 * TICK_BITS), .Depth(NUM_PORTS)) u_anchor_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  phgb_ram #(.Width(TICK_BITS), .Depth(NUM_PORTS)) u_grant_ram (
    .clk_i, .we_i(b_we), .waddr_i(p_q), .wdata_i(b_wdata),
    .raddr_i(p_q), .rdata_o(b_rdata)
  );

  logic [PortW-1:0]     qi;
  logic                 elig, div_ge;
  logic [TICK_BITS-1:0] safe_eff, old_span, old_lg, sd, grant, bound;
  logic [TICK_BITS:0]   sum;
  logic [31:0]          to_rate;
  logic [63:0]          span64, phi;
  logic [32:0]          div_cat, div_tr;
  logic [1:0]           grp_p;

  assign qi      = q_q[PortW-1:0];
  assign grp_p   = grp_of(32'(p_q), groups_q);
  assign to_rate = (32'(p_q) < RatePorts) ? rate_q[2'(p_q)] : 32'd1;
  assign elig    = (qi != p_q) && (grp_p != 2'd0) &&
                   (grp_of(32'(qi), groups_q) == grp_p) && att_of(32'(qi), att_q);
  assign span64  = 64'(span_q);
  assign phi     = 64'(span64[63:32]) * 64'(to_rate);
  assign div_cat = {rem_q, dvd_q[ProdBits-1]};
  assign div_tr  = div_cat - {1'b0, from_q};
  assign div_ge  = div_cat >= {1'b0, from_q};
  assign sum     = {1'b0, origin_q} + {1'b0, conv_q};
  assign bound   = sum[TICK_BITS] ? TickMask : sum[TICK_BITS-1:0];

  always_comb begin
    safe_eff = (safe_q < loc_q) ? loc_q : safe_q;
    old_span = anch_q[p_q] ? a_rdata[TICK_BITS-1:0] : '0;
    old_lg   = lgv_q[p_q] ? b_rdata : '0;
    origin_d = anch_q[p_q] ? a_rdata[2*TICK_BITS-1:TICK_BITS] : loc_q;
    sd       = (safe_eff > origin_d) ? safe_eff - origin_d : '0;
    grant    = (want_q < loc_q) ? loc_q : want_q;
    if (grant < lg_q) grant = lg_q;
  end

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    selok_d    = selok_q;
    loc_d      = loc_q;
    safe_d     = safe_q;
    want_d     = want_q;
    lg_d       = lg_q;
    ceil_d     = ceil_q;
    any_d      = any_q;
    q_d        = q_q;
    span_d     = span_q;
    conv_d     = conv_q;
    plo_d      = plo_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    from_d     = from_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_verd_d = out_verd_q;
    out_tick_d = out_tick_q;
    anch_d     = anch_q;
    lgv_d      = lgv_q;
    a_we       = 1'b0;
    a_waddr    = p_q;
    a_wdata    = {origin_d, (sd > old_span) ? sd : old_span};
    a_raddr    = p_q;
    b_we       = 1'b0;
    b_wdata    = lg_q;
    req_i.ready = (state_q == ST_IDLE);

    if (cfg_wr && cfg_idx == REG_GROUPS) anch_d = '0;
    if (cfg_wr && cfg_idx == REG_ATTACHED) begin
      for (int i = 0; i < PortLimit; i++) begin
        if (att_q[i] && !pwdata[i]) anch_d[i] = 1'b0;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          selok_d = 32'(req_i.port_sel) < NUM_PORTS;
          p_d     = PortW'(req_i.port_sel);
          loc_d   = req_i.local_now[TICK_BITS-1:0];
          safe_d  = req_i.safe_horizon[TICK_BITS-1:0];
          want_d  = req_i.wanted_tick[TICK_BITS-1:0];
          any_d   = 1'b0;
          ceil_d  = TickMask;
          q_d     = '0;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = (selok_q && att_of(32'(p_q), att_q)) ? ST_SELF : ST_FINISH;
      end
      ST_SELF: begin
        a_we      = 1'b1;
        anch_d[p_q] = 1'b1;
        lg_d      = (!anch_q[p_q] && old_lg < loc_q) ? loc_q : old_lg;
        b_wdata   = lg_d;
        b_we      = 1'b1;
        lgv_d[p_q] = 1'b1;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        a_raddr = qi;
        if (32'(q_q) >= NUM_PORTS) begin
          state_d = ST_FINISH;
        end else if (!elig) begin
          q_d = q_q + 1'b1;
        end else if (!anch_q[qi]) begin
          if (!any_q || origin_q < ceil_q) ceil_d = origin_q;
          any_d = 1'b1;
          q_d   = q_q + 1'b1;
        end else begin
          state_d = ST_PEER;
        end
      end
      ST_PEER: begin
        span_d = a_rdata[TICK_BITS-1:0];
        from_d = (32'(qi) < RatePorts) ? rate_q[2'(qi)] : 32'd1;
        if (from_d == to_rate) begin
          conv_d  = span_d;
          state_d = ST_BOUND;
        end else if (from_d == 32'd0 || to_rate == 32'd0 || span_d == '0) begin
          conv_d  = '0;
          state_d = ST_BOUND;
        end else begin
          plo_d   = 64'(span_d[31:0]) * 64'(to_rate);
          state_d = ST_MUL_HI;
        end
      end
      ST_MUL_HI: begin
        dvd_d   = {32'd0, plo_q} + {phi, 32'd0};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = div_ge ? div_tr[31:0] : div_cat[31:0];
        dvd_d = {dvd_q[ProdBits-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == DivSteps - 1) begin
          conv_d  = (|dvd_d[ProdBits-1:TICK_BITS]) ? TickMask : dvd_d[TICK_BITS-1:0];
          state_d = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (!any_q || bound < ceil_q) ceil_d = bound;
        any_d   = 1'b1;
        q_d     = q_q + 1'b1;
        state_d = ST_SCAN;
      end
      ST_FINISH: begin
        if (!out_vld_q || rsp_o.ready) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if (!any_q || ceil_q == TickMask) begin
            out_verd_d = VERD_UNB;
            out_tick_d = '1;
          end else if (ceil_q >= want_q) begin
            out_verd_d = VERD_GRANT;
            out_tick_d = 64'(grant);
            b_wdata    = grant;
            b_we       = 1'b1;
          end else begin
            out_verd_d = VERD_WAIT;
            out_tick_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      anch_q    <= '0;
      lgv_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      anch_q    <= anch_d;
      lgv_q     <= lgv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    selok_q    <= selok_d;
    loc_q      <= loc_d;
    safe_q     <= safe_d;
    want_q     <= want_d;
    if (state_q == ST_SELF) origin_q <= origin_d;
    lg_q       <= lg_d;
    ceil_q     <= ceil_d;
    any_q      <= any_d;
    q_q        <= q_d;
    span_q     <= span_d;
    conv_q     <= conv_d;
    plo_q      <= plo_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    from_q     <= from_d;
    out_verd_q <= out_verd_d;
    out_tick_q <= out_tick_d;
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.verdict    = out_verd_q;
  assign rsp_o.grant_tick = out_tick_q;

  `PHGB_ASSERT_NXT(a_accept_lookup, clk_i, rst_ni, req_i.valid && req_i.ready, state_q == ST_LOOKUP, "accepted word did not start a lookup")
  `PHGB_ASSERT_IMP(a_div_count, clk_i, rst_ni, state_q == ST_DIV, 32'(cnt_q) < DivSteps, "divider step count overrun")
  `PHGB_ASSERT_NXT(a_anchor_hold, clk_i, rst_ni, state_q == ST_IDLE && !cfg_wr, anch_q == $past(anch_q), "anchor flags changed while idle")

endmodule

/* hw/rtl/phgb_ram.sv */
// -----------------------------------------------------------------------------
// phgb_ram
// Generic one-write one-read RAM with registered read data.
// -----------------------------------------------------------------------------
module phgb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
